// ----- rtl/fbkt_pkg.sv -----
// package for the float bucketize unit
// types, constants and helper functions shared by the rtl; no dependencies
package fbkt_pkg;

   localparam int MAX_BOUNDARIES_DEFAULT = 256;

   localparam logic [1:0] FMT_INT32 = 2'd0;
   localparam logic [1:0] FMT_INT64 = 2'd1;
   localparam logic [1:0] FMT_FP32  = 2'd2;
   localparam logic [1:0] FMT_FP64  = 2'd3;

   localparam logic [1:0] CSR_RIGHT_MODE = 2'd0;
   localparam logic [1:0] CSR_COUNT      = 2'd1;
   localparam logic [1:0] CSR_FORMAT     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_ROUND,
      ST_SCAN,
      ST_CMP,
      ST_DONE
   } state_type;

   // ordering key: sign-magnitude to two's complement, -0 equals +0
   function automatic logic signed [32:0] order_key(input logic [31:0] b);
      logic signed [32:0] mag;
      begin
         mag = $signed({2'b00, b[30:0]});
         order_key = b[31] ? -mag : mag;
      end
   endfunction

   function automatic logic is_nan32(input logic [31:0] b);
      is_nan32 = (b[30:0] > 31'h7F800000);
   endfunction

endpackage

// ----- rtl/float_bucketize_unit.sv -----
// float bucketize unit: converts a sample to float32 and counts table boundaries below it
// depends on fbkt_pkg; in right mode boundaries equal to the sample count too
//
//  channel | ports                                   | direction
//  req     | req_valid req_stall req_mode ...        | in
//  rsp     | rsp_valid rsp_stall rsp_bucket_index    | out
//  csr     | csr_write csr_index csr_data            | in
//
// a float32 query holds the input through one table read, one compare per boundary
// in use and one result step; a NaN sample or an empty table skips the compares
// int and float64 samples first get one normalize shift per cycle, then rounding
// reset is synchronous; the table is not cleared
// a result waiting under rsp_stall blocks the unit only once the next result is ready
module float_bucketize_unit #(
   parameter int MAX_BOUNDARIES = fbkt_pkg::MAX_BOUNDARIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_entry_index,
   input  logic [31:0] req_boundary_bits,
   input  logic [63:0] req_sample_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_bucket_index,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);
   localparam int AW = (MAX_BOUNDARIES > 1) ? $clog2(MAX_BOUNDARIES) : 1;
   localparam int CW = $clog2(MAX_BOUNDARIES + 1);

   fbkt_pkg::state_type state_ff, state_in;

   logic        right_ff;
   logic [8:0]  count_ff;
   logic [1:0]  fmt_ff;

   logic [31:0] table_mem [MAX_BOUNDARIES];
   logic [31:0] rd_ff;

   logic        neg_ff, neg_in;
   logic [63:0] sig_ff, sig_in;
   logic signed [12:0] exp_ff, exp_in;   // value = sig * 2^exp
   logic [31:0] x_ff, x_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] lim_ff;
   logic [8:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff;
   logic [8:0]  rsp_index_ff;

   logic accept;
   logic done_fire;
   assign req_stall = (state_ff != fbkt_pkg::ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_bucket_index = rsp_index_ff;
   // a finished count moves to the output register once the old result has left
   assign done_fire = (state_ff == fbkt_pkg::ST_DONE) && !(rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff <= 1'b0;
         count_ff <= '0;
         fmt_ff   <= fbkt_pkg::FMT_FP32;
      end else if (csr_write) begin
         unique case (csr_index)
            fbkt_pkg::CSR_RIGHT_MODE: right_ff <= csr_data[0];
            fbkt_pkg::CSR_COUNT:      count_ff <= csr_data;
            fbkt_pkg::CSR_FORMAT:     fmt_ff   <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // table write on a load transfer, registered read during the scan
   always_ff @(posedge clock) begin
      if (accept && !req_mode && ({24'd0, req_entry_index} < 32'(MAX_BOUNDARIES)))
         table_mem[req_entry_index[AW-1:0]] <= req_boundary_bits;
      rd_ff <= table_mem[idx_ff[AW-1:0]];
   end

   // rounding helpers: keep the top 24 bits at normalized sig[63:40]
   logic signed [12:0] top_exp;      // exponent of sig[63]
   logic signed [12:0] sh;           // extra right shift for subnormals
   logic [63:0] shifted;
   logic        sticky_sub;
   logic [24:0] q;
   logic        rnd_bit, stk;
   logic signed [12:0] biased;
   logic [31:0] rounded;

   always_comb begin
      top_exp = exp_ff + 13'sd63;
      // float32 lsb exponent is top_exp-23, must be >= -149
      sh = -13'sd126 - top_exp;
      if (sh < 0) sh = '0;
      if (sh > 13'sd30) sh = 13'sd30;
      shifted = sig_ff >> sh[4:0];
      sticky_sub = |(sig_ff & ((64'd1 << sh[4:0]) - 64'd1));
      q = {1'b0, shifted[63:40]};
      rnd_bit = shifted[39];
      stk = (|shifted[38:0]) || sticky_sub;
      if (rnd_bit && (stk || q[0])) q = q + 25'd1;
      biased = top_exp + 13'sd127 + 13'(sh);
      if (q[24]) begin
         q = q >> 1;
         biased = biased + 13'sd1;
      end
      if (top_exp < -13'sd160) rounded = {neg_ff, 31'd0};
      else if (!q[23]) rounded = {neg_ff, 8'd0, q[22:0]};
      else if (biased >= 13'sd255) rounded = {neg_ff, 31'h7F800000};
      else rounded = {neg_ff, biased[7:0], q[22:0]};
   end

   logic [31:0] b_cmp;
   logic signed [32:0] kx, kb;
   logic hit;
   always_comb begin
      b_cmp = rd_ff;
      kx = fbkt_pkg::order_key(x_ff);
      kb = fbkt_pkg::order_key(b_cmp);
      hit = !fbkt_pkg::is_nan32(b_cmp) && (right_ff ? (kb <= kx) : (kb < kx));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fbkt_pkg::ST_IDLE:
            if (accept && req_mode) begin
               if (fmt_ff == fbkt_pkg::FMT_FP32) state_in = fbkt_pkg::ST_SCAN;
               else state_in = fbkt_pkg::ST_NORM;
            end
         fbkt_pkg::ST_NORM:
            if (sig_ff == '0) state_in = fbkt_pkg::ST_SCAN;
            else if (sig_ff[63]) state_in = fbkt_pkg::ST_ROUND;
         fbkt_pkg::ST_ROUND: state_in = fbkt_pkg::ST_SCAN;
         fbkt_pkg::ST_SCAN:
            if (fbkt_pkg::is_nan32(x_ff) || lim_ff == '0) state_in = fbkt_pkg::ST_DONE;
            else state_in = fbkt_pkg::ST_CMP;
         fbkt_pkg::ST_CMP:
            if (idx_ff == lim_ff) state_in = fbkt_pkg::ST_DONE;
         fbkt_pkg::ST_DONE:
            if (done_fire) state_in = fbkt_pkg::ST_IDLE;
         default: state_in = fbkt_pkg::ST_IDLE;
      endcase
   end

   // datapath updates
   logic [63:0] raw_ext;
   always_comb begin
      neg_in = neg_ff;
      sig_in = sig_ff;
      exp_in = exp_ff;
      x_in = x_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      raw_ext = (fmt_ff == fbkt_pkg::FMT_INT32) ?
                {{32{req_sample_bits[31]}}, req_sample_bits[31:0]} : req_sample_bits;
      unique case (state_ff)
         fbkt_pkg::ST_IDLE: begin
            cnt_in = '0;
            idx_in = '0;
            x_in = req_sample_bits[31:0];
            neg_in = raw_ext[63];
            if (fmt_ff == fbkt_pkg::FMT_FP64) begin
               neg_in = req_sample_bits[63];
               if (req_sample_bits[62:52] == 11'h7FF) begin
                  x_in = (req_sample_bits[51:0] != '0) ? {req_sample_bits[63], 31'h7FC00000}
                                                       : {req_sample_bits[63], 31'h7F800000};
                  sig_in = '0;
               end else if (req_sample_bits[62:52] == '0) begin
                  sig_in = {12'd0, req_sample_bits[51:0]};
                  exp_in = -13'sd1074;
                  x_in = {req_sample_bits[63], 31'd0};
               end else begin
                  sig_in = {12'd1, req_sample_bits[51:0]};
                  exp_in = 13'(req_sample_bits[62:52]) - 13'sd1075;
                  x_in = {req_sample_bits[63], 31'd0};
               end
            end else if (fmt_ff != fbkt_pkg::FMT_FP32) begin
               sig_in = raw_ext[63] ? (64'd0 - raw_ext) : raw_ext;
               exp_in = '0;
               x_in = {raw_ext[63], 31'd0};
               if (raw_ext == '0) x_in = '0;
            end
         end
         fbkt_pkg::ST_NORM:
            if (sig_ff != '0 && !sig_ff[63]) begin
               sig_in = sig_ff << 1;
               exp_in = exp_ff - 13'sd1;
            end
         fbkt_pkg::ST_ROUND: x_in = rounded;
         fbkt_pkg::ST_SCAN: idx_in = idx_ff + 1'b1;
         fbkt_pkg::ST_CMP: begin
            if (hit) cnt_in = cnt_ff + 9'd1;
            idx_in = idx_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbkt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (done_fire) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      sig_ff <= sig_in;
      exp_ff <= exp_in;
      x_ff <= x_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      if (done_fire) rsp_index_ff <= cnt_ff;
      if (state_ff == fbkt_pkg::ST_IDLE)
         lim_ff <= ({23'd0, count_ff} > 32'(MAX_BOUNDARIES)) ? CW'(MAX_BOUNDARIES)
                                                            : CW'(count_ff);
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != fbkt_pkg::ST_IDLE) |-> req_stall)
      else $error("transfer taken while busy");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbkt_pkg::ST_DONE) |=> rsp_valid)
      else $error("missing result");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbkt_pkg::ST_CMP) |-> (cnt_ff <= 9'(idx_ff)))
      else $error("count exceeds scanned entries");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_bucket_index)))
      else $error("stalled result changed");
endmodule

// ----- dv/tb.sv -----
// testbench for float_bucketize_unit: random and directed loads and queries, scoreboard check
// depends on fbkt_pkg and rtl/float_bucketize_unit.sv
`timescale 1ns / 100ps

class bucket_scoreboard;
   logic [31:0] bounds[256];
   logic        right_mode;
   logic [8:0]  bound_count;
   logic [1:0]  sample_fmt;
   logic [8:0]  bucket_q[$];
   int          errors;

   function new();
      right_mode  = 1'b0;
      bound_count = 9'd0;
      sample_fmt  = fbkt_pkg::FMT_FP32;
      errors      = 0;
      foreach (bounds[i]) bounds[i] = 32'h0;
   endfunction

   // (-1)^neg * sig * 2^e to float32, nearest even; sig nonzero
   static function logic [31:0] round_f32(bit neg, logic [63:0] sig, int e);
      int          p, sh, lsb;
      logic [63:0] q, rem, half;
      logic [31:0] s;
      s = neg ? 32'h8000_0000 : 32'h0;
      p = 63;
      while (!sig[p]) p--;
      sh = p - 23;
      if (-149 - e > sh) sh = -149 - e;
      if (sh > p + 1) return s;
      else if (sh == p + 1) q = (sig > (64'd1 << p)) ? 64'd1 : 64'd0;
      else if (sh <= 0) q = sig << (-sh);
      else begin
         rem  = sig & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         q    = sig >> sh;
         if (rem > half || (rem == half && q[0])) q++;
      end
      if (q == 0) return s;
      lsb = e + sh;
      if (q >= (64'd1 << 24)) begin
         q = q >> 1;
         lsb++;
      end
      if (q >= (64'd1 << 23)) begin
         if (lsb + 150 >= 255) return s | 32'h7F80_0000;
         return s | (32'(lsb + 150) << 23) | {9'd0, q[22:0]};
      end
      return s | q[31:0];
   endfunction

   static function logic [31:0] int_f32(logic [63:0] raw);
      logic [63:0] mag;
      mag = raw[63] ? -raw : raw;
      if (mag == 0) return 32'h0;
      return round_f32(raw[63], mag, 0);
   endfunction

   static function logic [31:0] dbl_f32(logic [63:0] raw);
      logic [31:0] s;
      int          ex;
      logic [63:0] fr;
      s  = raw[63] ? 32'h8000_0000 : 32'h0;
      ex = int'(raw[62:52]);
      fr = {12'd0, raw[51:0]};
      if (ex == 'h7FF) return (fr != 0) ? (s | 32'h7FC0_0000) : (s | 32'h7F80_0000);
      if (ex == 0) begin
         if (fr == 0) return s;
         return round_f32(raw[63], fr, -1074);
      end
      return round_f32(raw[63], fr | (64'd1 << 52), ex - 1075);
   endfunction

   static function bit nan32(logic [31:0] b);
      return b[30:0] > 31'h7F80_0000;
   endfunction

   static function logic signed [32:0] key32(logic [31:0] b);
      logic signed [32:0] mag;
      mag = $signed({2'b00, b[30:0]});
      return b[31] ? -mag : mag;
   endfunction

   function automatic logic [8:0] count_below(logic [63:0] raw);
      logic [31:0]        x;
      logic signed [32:0] kx, kb;
      int                 n, cnt;
      case (sample_fmt)
         fbkt_pkg::FMT_INT32: x = int_f32({{32{raw[31]}}, raw[31:0]});
         fbkt_pkg::FMT_INT64: x = int_f32(raw);
         fbkt_pkg::FMT_FP32:  x = raw[31:0];
         default:             x = dbl_f32(raw);
      endcase
      n = (bound_count > 256) ? 256 : int'(bound_count);
      cnt = 0;
      if (nan32(x)) return 9'd0;
      kx = key32(x);
      for (int i = 0; i < n; i++) begin
         if (nan32(bounds[i])) continue;
         kb = key32(bounds[i]);
         if (right_mode ? (kb <= kx) : (kb < kx)) cnt++;
      end
      return 9'(cnt);
   endfunction

   function void record_input(logic mode, logic [7:0] idx, logic [31:0] bb, logic [63:0] sb);
      if (mode == 1'b0) bounds[idx] = bb;
      else bucket_q.push_back(count_below(sb));
   endfunction

   function void check_result(logic [8:0] got);
      logic [8:0] want;
      if (bucket_q.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result: bucket %0d", got);
         return;
      end
      want = bucket_q.pop_front();
      if (got !== want) begin
         errors++;
         if (errors <= 10) $display("bucket mismatch: expected %0d, got %0d", want, got);
      end
   endfunction
endclass

module tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [7:0]  req_entry_index = 8'd0;
   logic [31:0] req_boundary_bits = 32'd0;
   logic [63:0] req_sample_bits = 64'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [8:0]  rsp_bucket_index;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = fbkt_pkg::CSR_RIGHT_MODE;
   logic [8:0]  csr_data = 9'd0;

   localparam int DRAIN_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   bucket_scoreboard sb = new();
   bit          idle_on = 1'b1;
   bit          long_hold = 1'b0;
   int          quiet_cycles = 0;
   logic [63:0] int_pool[$];

   float_bucketize_unit dut (.*);

   always #1 clock = ~clock;

   // result side: random stall bursts plus one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // result check and watchdog on transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_bucket_index);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_req(logic mode, logic [7:0] idx, logic [31:0] bb, logic [63:0] sb_bits);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_entry_index   <= idx;
      req_boundary_bits <= bb;
      req_sample_bits   <= sb_bits;
      do @(posedge clock); while (req_stall);
      sb.record_input(mode, idx, bb, sb_bits);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.bucket_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves csr_write high; the caller drops it after the last write
   task automatic write_csr(logic [1:0] idx, logic [8:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         fbkt_pkg::CSR_RIGHT_MODE: sb.right_mode  = val[0];
         fbkt_pkg::CSR_COUNT:      sb.bound_count = val;
         fbkt_pkg::CSR_FORMAT:     sb.sample_fmt  = val[1:0];
         default: ;
      endcase
   endtask

   function automatic logic [63:0] rand_int();
      logic [63:0] v;
      int          len;
      len = $urandom_range(1, 63);
      v = {$urandom, $urandom} & ((64'd1 << len) - 64'd1);
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   function automatic logic [31:0] make_bound();
      logic [63:0] v;
      int          r;
      r = $urandom_range(0, 9);
      if (r < 5) begin
         v = rand_int();
         int_pool.push_back(v);
         return sb.int_f32(v);
      end
      if (r < 9) return {1'($urandom), 8'($urandom_range(100, 160)), 23'($urandom)};
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7F80_0000;
         3: return 32'hFF80_0000;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function automatic logic [63:0] widen(logic [31:0] f);
      if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'd0};
      if (f[30:23] == 8'h00) return {f[31], 63'd0};
      return {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0};
   endfunction

   function automatic logic [63:0] special_sample(logic [1:0] fmt, int k);
      case (fmt)
         fbkt_pkg::FMT_INT32: case (k)
            0: return 64'h0;
            1: return 64'h7FFF_FFFF;
            2: return 64'h8000_0000;
            3: return 64'hFFFF_FFFF;
            4: return 64'hFFFF_FFFF_0100_0001;
            default: return 64'h0000_0000_0123_4567;
         endcase
         fbkt_pkg::FMT_INT64: case (k)
            0: return 64'h0;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'hFFFF_FFFF_FFFF_FFFF;
            4: return 64'h0000_0000_0100_0001;
            default: return 64'h00FF_FFFF_8000_0000;
         endcase
         fbkt_pkg::FMT_FP32: case (k)
            0: return 64'h0;
            1: return 64'h8000_0000;
            2: return 64'h7F80_0000;
            3: return 64'hFF80_0000;
            4: return 64'h7FC0_0000;
            default: return 64'hFFFF_FFFF_0000_0001;
         endcase
         default: case (k)
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FF0_0000_0000_0000;
            2: return 64'hFFF8_0000_0000_0001;
            3: return 64'hC7F0_0000_0000_0000;   // past float32 range
            4: return 64'h3690_0000_0000_0001;   // float32 subnormal territory
            default: return 64'h0000_0000_0000_0001;
         endcase
      endcase
   endfunction

   function automatic logic [63:0] rand_sample(logic [1:0] fmt);
      logic [31:0] t;
      int          r;
      r = $urandom_range(0, 9);
      t = sb.bounds[$urandom_range(0, 255)];
      if (r < 2) return {$urandom, $urandom};
      if (r < 3) return special_sample(fmt, $urandom_range(0, 5));
      case (fmt) inside
         fbkt_pkg::FMT_INT32, fbkt_pkg::FMT_INT64:
            if (r < 7 && int_pool.size() != 0) return int_pool[$urandom_range(0, int_pool.size() - 1)];
            else return rand_int();
         fbkt_pkg::FMT_FP32:
            if (r < 7) return {$urandom, t};
            else return {$urandom, t + 32'($urandom_range(0, 2)) - 32'd1};
         default:
            if (r < 7) return widen(t);
            else return widen(t) ^ 64'($urandom_range(0, 1 << 29));
      endcase
   endfunction

   typedef struct {
      logic       rm;
      logic [8:0] cnt;
      logic [1:0] fmt;
      int         items;
   } phase_type;

   phase_type phases[12];
   logic signed [32:0] keys[256];
   logic [31:0]        b;

   initial begin
      phases = '{
         '{1'b0, 9'd256, fbkt_pkg::FMT_FP32, 40},  '{1'b1, 9'd256, fbkt_pkg::FMT_FP64, 40},
         '{1'b0, 9'd0,   fbkt_pkg::FMT_INT32, 100}, '{1'b1, 9'd511, fbkt_pkg::FMT_INT64, 30},
         '{1'b0, 9'd8,   fbkt_pkg::FMT_FP32, 240}, '{1'b1, 9'd16,  fbkt_pkg::FMT_FP64, 240},
         '{1'b0, 9'd12,  fbkt_pkg::FMT_INT32, 220}, '{1'b1, 9'd5,  fbkt_pkg::FMT_INT64, 220},
         '{1'b0, 9'd32,  fbkt_pkg::FMT_FP64, 200}, '{1'b1, 9'd1,   fbkt_pkg::FMT_FP32, 120},
         '{1'b0, 9'd64,  fbkt_pkg::FMT_INT64, 120}, '{1'b1, 9'd20, fbkt_pkg::FMT_FP32, 150}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sorted table, every entry written before any query reads it
      foreach (keys[i]) keys[i] = sb.key32(make_bound());
      keys.sort();
      foreach (keys[i]) begin
         b = (keys[i] < 0) ? {1'b1, 31'(-keys[i])} : {1'b0, 31'(keys[i])};
         send_req(1'b0, 8'(i), b, {$urandom, $urandom});
      end

      foreach (phases[p]) begin
         drain();
         if (p == $size(phases) - 1) idle_on = 1'b0;
         write_csr(fbkt_pkg::CSR_RIGHT_MODE, {8'd0, phases[p].rm});
         write_csr(fbkt_pkg::CSR_COUNT, phases[p].cnt);
         write_csr(fbkt_pkg::CSR_FORMAT, {7'd0, phases[p].fmt});
         csr_write <= 1'b0;
         if (p == 4) long_hold = 1'b1;
         for (int k = 0; k < 6; k++)
            send_req(1'b1, 8'($urandom), $urandom, special_sample(phases[p].fmt, k));
         for (int k = 0; k < phases[p].items; k++) begin
            if (p == 5 && k == phases[p].items / 2) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (sb.bucket_q.size() != 0);
            end
            if ($urandom_range(0, 4) == 0) begin
               // overwrites make the table unsorted, sometimes with a NaN
               case ($urandom_range(0, 3))
                  0: b = $urandom;
                  1: b = {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
                  default: b = make_bound();
               endcase
               send_req(1'b0, 8'($urandom), b, {$urandom, $urandom});
            end else begin
               send_req(1'b1, 8'($urandom), $urandom, rand_sample(phases[p].fmt));
            end
         end
      end

      drain();
      if (sb.errors == 0 && sb.bucket_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ----- files.f -----
rtl/fbkt_pkg.sv
rtl/float_bucketize_unit.sv
dv/tb.sv
